@@ hdl/npcm_pkg.sv @@
// ----------------------------------------------------------------------------
// npcm_pkg: shared types and constants for the nearest palette color match
// Palette geometry, field widths, register map and the operation codes.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

  localparam int COMP_W = 8;                 // one color component
  localparam int SQ_W   = 2 * COMP_W;        // square of a component difference
  localparam int DIST_W = SQ_W + 2;          // sum of three squares
  localparam int OUT_W  = 8;                 // nearest_index field
  localparam int EIU_W  = 9;                 // entries_in_use register
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index (word address) of entries_in_use
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  localparam logic [EIU_W-1:0] EIU_RESET = EIU_W'(256);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    rgb_t             rgb;
  } pal_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } pal_rd_t;

endpackage

@@ hdl/npcm_palette_ram.sv @@
// ----------------------------------------------------------------------------
// npcm_palette_ram: palette storage
// One write and one registered read per cycle. Per-entry valid bits make an
// entry that was never written read as the grayscale ramp value i,i,i.
// ----------------------------------------------------------------------------
module npcm_palette_ram (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  npcm_pkg::pal_wr_t wr_i,
  input  npcm_pkg::pal_rd_t rd_i,
  output npcm_pkg::rgb_t    rd_rgb_o
);
  import npcm_pkg::*;

  rgb_t                     mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] written_q;
  rgb_t                     rdata_q;
  logic                     rd_written_q;
  logic [IDX_W-1:0]         rd_addr_q;
  logic [COMP_W-1:0]        gray;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.rgb;
    end
    if (rd_i.en) begin
      rdata_q   <= mem[rd_i.addr];
      rd_addr_q <= rd_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_written_q <= written_q[rd_i.addr];
      end
    end
  end

  assign gray     = COMP_W'(rd_addr_q);
  // red, green, blue from the high bits down
  assign rd_rgb_o = rd_written_q ? rdata_q : {gray, gray, gray};

endmodule

@@ hdl/nearest_palette_color_match.sv @@
// A query reads count = min(entries_in_use, 256) palette entries, one entry per
// cycle; with count = 0 no entry is read and the result is index 0.
// A palette write gives no output transfer. Input ready is low while a query
// scans or its result waits for the output register to be free.
// Reset (async, low) restores the grayscale palette and sets entries_in_use to 256.
// ----------------------------------------------------------------------------
// nearest_palette_color_match: nearest RGB palette entry search
// Scans the palette through one shared distance unit (abs diff, square,
// sum, compare), keeping the lowest index of the smallest squared distance.
// ----------------------------------------------------------------------------
module nearest_palette_color_match (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // APB configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [npcm_pkg::APB_AW-1:0]          paddr,
  input  logic [npcm_pkg::APB_DW-1:0]          pwdata,
  output logic [npcm_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [npcm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: op[0]
  input  logic                                 s_axis_tuser,
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: nearest_index[7:0]
  output logic [npcm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import npcm_pkg::*;

  // configuration
  logic [EIU_W-1:0] eiu_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRIES_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eiu_q <= EIU_RESET;
    end else if (cfg_wr) begin
      eiu_q <= pwdata[EIU_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? APB_DW'(eiu_q) : '0;

  // input unpacking
  logic [7:0] in_entry_index;
  rgb_t       in_rgb;
  logic       in_xfer;
  op_e        in_op;

  assign in_entry_index = s_axis_tdata[7:0];
  assign in_rgb         = '{red: s_axis_tdata[15:8], green: s_axis_tdata[23:16],
                            blue: s_axis_tdata[31:24]};
  assign in_op          = op_e'(s_axis_tuser);
  assign in_xfer        = s_axis_tvalid && s_axis_tready;

  // sequencer
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  addr_q, count_q;
  logic              start_query;
  logic              rd_en;
  logic              out_load;
  rgb_t              pix_q;
  logic [CNT_W-1:0]  count_sat;

  assign count_sat = (eiu_q > EIU_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                      : CNT_W'(eiu_q);

  // pipeline of the distance unit
  logic              p1_q, p2_q;
  logic [IDX_W-1:0]  p1_idx_q, p2_idx_q;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [DIST_W-1:0] dist_sum, best_dist_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              have_q;
  logic              out_vld_q;
  logic [OUT_W-1:0]  out_idx_q;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    start_query   = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (in_op == OP_QUERY)) begin
          start_query = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = (addr_q != count_q);
        if (!rd_en && !p1_q && !p2_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
      count_q <= '0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_q    <= rd_en;
      p2_q    <= p1_q;
      if (start_query) begin
        addr_q  <= '0;
        count_q <= count_sat;
        have_q  <= 1'b0;
      end else begin
        if (rd_en) begin
          addr_q <= addr_q + 1'b1;
        end
        if (p2_q) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  // palette memory
  pal_wr_t pal_wr;
  pal_rd_t pal_rd;
  rgb_t    ent;

  assign pal_wr.en   = in_xfer && (in_op == OP_WRITE) &&
                       ({1'b0, in_entry_index} < 9'(PALETTE_DEPTH));
  assign pal_wr.addr = in_entry_index[IDX_W-1:0];
  assign pal_wr.rgb  = in_rgb;
  assign pal_rd.en   = rd_en;
  assign pal_rd.addr = addr_q[IDX_W-1:0];

  npcm_palette_ram u_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (pal_wr),
    .rd_i     (pal_rd),
    .rd_rgb_o (ent)
  );

  // distance unit: abs differences and squares, then sum and compare
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                              input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  always_ff @(posedge clk_i) begin
    if (start_query) begin
      pix_q       <= in_rgb;
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else if (p2_q && (!have_q || (dist_sum < best_dist_q))) begin
      best_idx_q  <= p2_idx_q;
      best_dist_q <= dist_sum;
    end
    p1_idx_q <= addr_q[IDX_W-1:0];
    p2_idx_q <= p1_idx_q;
    sq_r_q   <= sq_diff(pix_q.red, ent.red);
    sq_g_q   <= sq_diff(pix_q.green, ent.green);
    sq_b_q   <= sq_diff(pix_q.blue, ent.blue);
  end

  assign dist_sum = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q <= OUT_W'(best_idx_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_idx_q);

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for nearest_palette_color_match
// Drives palette writes and pixel queries on the input stream, reprograms
// entries_in_use over APB between phases, and checks every output transfer
// against a typed-in index or a nearest search of a local palette copy.
// ----------------------------------------------------------------------------
module tb_top;
  import npcm_pkg::*;

  localparam logic REG_SPARE       = 1'b1;  // unmapped register index
  localparam int   WATCHDOG_LIMIT  = 4000;
  localparam int   HOLD_CYCLES     = 600;
  localparam int   NUM_PHASES      = 8;
  localparam int   ITEMS_PER_PHASE = 200;
  localparam int   MAX_REPORTS     = 10;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    op_e               op;
    logic [IDX_W-1:0]  entry;
    rgb_t              color;
    logic              reg_sel;
    logic [APB_DW-1:0] value;
    logic              known;
    logic [OUT_W-1:0]  nearest;
  } row_t;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_AW-1:0]      paddr   = '0;
  logic [APB_DW-1:0]      pwdata  = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;
  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // travel with each input transfer: typed-in expectation for table rows
  logic                   row_known   = 1'b0;
  logic [OUT_W-1:0]       row_nearest = '0;

  rgb_t                   pal_model [PALETTE_DEPTH];
  logic [EIU_W-1:0]       eiu_shadow = EIU_RESET;
  logic [OUT_W-1:0]       nearest_q [$];
  logic [OUT_W-1:0]       want_idx;
  int unsigned            errors      = 0;
  int unsigned            idle_cycles = 0;
  bit                     sending     = 1'b0;
  bit                     no_idle     = 1'b0;
  bit                     hold_req    = 1'b0;
  row_t                   plan [$];

  nearest_palette_color_match i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  function automatic void expect_idx(logic [OUT_W-1:0] idx);
    nearest_q = {nearest_q, idx};
  endfunction

  function automatic int unsigned searched_span();
    return (eiu_shadow > PALETTE_DEPTH) ? PALETTE_DEPTH : eiu_shadow;
  endfunction

  // lowest index of the smallest squared RGB distance
  function automatic logic [OUT_W-1:0] nearest_entry(rgb_t px);
    int unsigned span;
    int unsigned d2;
    int unsigned best_dist;
    int          dr;
    int          dg;
    int          db;
    logic [OUT_W-1:0] best;
    span      = searched_span();
    best      = '0;
    best_dist = 0;
    for (int unsigned i = 0; i < span; i++) begin
      dr = int'(px.red)   - int'(pal_model[i].red);
      dg = int'(px.green) - int'(pal_model[i].green);
      db = int'(px.blue)  - int'(pal_model[i].blue);
      d2 = dr * dr + dg * dg + db * db;
      if (i == 0 || d2 < best_dist) begin
        best_dist = d2;
        best      = i[OUT_W-1:0];
      end
    end
    return best;
  endfunction

  function automatic logic [COMP_W-1:0] nudge(logic [COMP_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[COMP_W-1:0];
  endfunction

  function automatic rgb_t rand_color();
    rgb_t c;
    c = '{COMP_W'($urandom_range(0, 255)), COMP_W'($urandom_range(0, 255)),
          COMP_W'($urandom_range(0, 255))};
    return c;
  endfunction

  function automatic row_t query_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic known, logic [OUT_W-1:0] nearest);
    row_t row;
    row         = '0;
    row.kind    = ROW_ITEM;
    row.op      = OP_QUERY;
    row.entry   = IDX_W'($urandom_range(0, 255));
    row.color   = '{r, g, b};
    row.known   = known;
    row.nearest = nearest;
    return row;
  endfunction

  function automatic row_t write_row(logic [IDX_W-1:0] entry, logic [7:0] r,
                                     logic [7:0] g, logic [7:0] b);
    row_t row;
    row       = '0;
    row.kind  = ROW_ITEM;
    row.op    = OP_WRITE;
    row.entry = entry;
    row.color = '{r, g, b};
    return row;
  endfunction

  function automatic row_t cfg_row(logic reg_sel, logic [APB_DW-1:0] value);
    row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_sel = reg_sel;
    row.value   = value;
    return row;
  endfunction

  task automatic send_item(input op_e op, input logic [IDX_W-1:0] entry, input rgb_t color,
                           input logic known, input logic [OUT_W-1:0] nearest);
    if (sending && !no_idle && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid    <= 1'b1;
    s_tuser     <= op;
    s_tdata     <= {color.blue, color.green, color.red, entry};
    row_known   <= known;
    row_nearest <= nearest;
    sending = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop offering items and let every pending query come out
  task automatic drain();
    if (sending) begin
      s_tvalid <= 1'b0;
      sending = 1'b0;
    end
    @(posedge clk_i);
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic reg_sel, input logic [APB_DW-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == REG_ENTRIES_IN_USE) eiu_shadow = value[EIU_W-1:0];
    // read back entries_in_use right after
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_ENTRIES_IN_USE, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[EIU_W-1:0] !== eiu_shadow) begin
      note_mismatch("entries_in_use readback", int'(eiu_shadow), int'(prdata[EIU_W-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // input transfers: update the palette copy or queue the expected index
  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_axis_tready) begin
      if (s_tuser == OP_WRITE) begin
        pal_model[s_tdata[7:0]] = '{s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
      end else if (row_known) begin
        expect_idx(row_nearest);
      end else begin
        expect_idx(nearest_entry('{s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]}));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (nearest_q.size() == 0) begin
        note_mismatch("unexpected result, nearest_index", -1, int'(m_axis_tdata));
      end else begin
        want_idx = nearest_q.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== want_idx) begin
          note_mismatch("nearest_index", int'(want_idx), int'(m_axis_tdata[OUT_W-1:0]));
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      m_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
    end
    m_tready <= no_idle || ($urandom_range(99) >= 26);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned      span;
    int unsigned      sel;
    int unsigned      eiu_val;
    logic [IDX_W-1:0] entry;
    rgb_t             color;
    op_e              op;

    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      pal_model[i] = '{i[7:0], i[7:0], i[7:0]};
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // grayscale palette after reset, then ties, zero and saturated counts
    plan = '{
      query_row(8'h00, 8'h00, 8'h00, 1'b1, 8'd0),
      query_row(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd255),
      query_row(8'h80, 8'h80, 8'h80, 1'b1, 8'd128),
      query_row(8'hFF, 8'h00, 8'h00, 1'b0, 8'd0),
      query_row(8'h00, 8'hFF, 8'h00, 1'b0, 8'd0),
      query_row(8'h00, 8'h00, 8'hFF, 1'b0, 8'd0),
      write_row(8'd0,   8'hFF, 8'h00, 8'h00),
      write_row(8'd1,   8'hFF, 8'h00, 8'h00),
      query_row(8'hFF, 8'h00, 8'h00, 1'b1, 8'd0),
      write_row(8'd255, 8'h00, 8'h00, 8'hFF),
      query_row(8'h00, 8'h00, 8'hFF, 1'b1, 8'd255),
      write_row(8'd170, 8'hAA, 8'h55, 8'hAA),
      query_row(8'hAA, 8'h55, 8'hAA, 1'b1, 8'd170),
      write_row(8'd85,  8'h55, 8'hAA, 8'h55),
      query_row(8'h55, 8'hAA, 8'h55, 1'b1, 8'd85),
      cfg_row(REG_ENTRIES_IN_USE, 32'd1),
      query_row(8'h00, 8'h00, 8'hFF, 1'b1, 8'd0),
      cfg_row(REG_ENTRIES_IN_USE, 32'd0),
      query_row(8'h0C, 8'h22, 8'h38, 1'b1, 8'd0),
      cfg_row(REG_SPARE, 32'd256),
      query_row(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd0),
      cfg_row(REG_ENTRIES_IN_USE, 32'hFFFF_FFFF),
      query_row(8'h00, 8'h00, 8'hFF, 1'b1, 8'd255),
      cfg_row(REG_ENTRIES_IN_USE, 32'd2),
      query_row(8'h00, 8'h00, 8'h00, 1'b1, 8'd0),
      cfg_row(REG_ENTRIES_IN_USE, 32'd256),
      query_row(8'h01, 8'h01, 8'h01, 1'b0, 8'd0)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        reconfigure(plan[i].reg_sel, plan[i].value);
      end else begin
        send_item(plan[i].op, plan[i].entry, plan[i].color, plan[i].known, plan[i].nearest);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       eiu_val = 16;
        1:       eiu_val = 256;
        2:       eiu_val = 8;
        3:       eiu_val = 1;
        4:       eiu_val = 40;
        5:       eiu_val = $urandom_range(2, 64);
        6:       eiu_val = 300;
        default: eiu_val = 0;
      endcase
      reconfigure(REG_ENTRIES_IN_USE, ($urandom() & ~32'h1FF) | eiu_val);
      no_idle = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      span = searched_span();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 5 && n == ITEMS_PER_PHASE / 2) drain();
        if ($urandom_range(99) < 35) begin
          op    = OP_WRITE;
          entry = IDX_W'((span > 0 && $urandom_range(99) < 80) ? $urandom_range(0, span - 1)
                                                               : $urandom_range(0, 255));
          if ($urandom_range(99) < 20) begin
            // duplicate color for ties
            color = pal_model[IDX_W'($urandom_range(0, 255))];
          end else begin
            color = rand_color();
          end
        end else begin
          op    = OP_QUERY;
          entry = IDX_W'($urandom_range(0, 255));
          sel   = $urandom_range(99);
          if (sel < 40 && span > 0) begin
            color = pal_model[IDX_W'($urandom_range(0, span - 1))];
            color = '{nudge(color.red), nudge(color.green), nudge(color.blue)};
          end else if (sel < 55) begin
            color = '{$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                      $urandom_range(1) ? 8'hFF : 8'h00};
          end else begin
            color = rand_color();
          end
        end
        send_item(op, entry, color, 1'b0, '0);
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (nearest_q.size() != 0) begin
        $display("%0d expected results never arrived", nearest_q.size());
      end
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
